/* rtl/bottom_up_merge_sorter_top_defines.svh */
// Assertion macros for the bottom-up merge sorter.
`ifndef BOTTOM_UP_MERGE_SORTER_TOP_DEFINES_SVH
`define BOTTOM_UP_MERGE_SORTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BUMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bums: same-cycle check failed");
`define BUMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bums: next-cycle check failed");
`else
`define BUMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BUMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/bums_pkg.sv */
// Shared constants and types of the bottom-up merge sorter.
package bums_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = CNT_W + 1;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
        addr_t rd_addr_a;
        addr_t rd_addr_b;
    } bums_mem_req_t;

endpackage

/* rtl/bottom_up_merge_sorter_top.sv */
// Top level of the bottom-up merge sorter: handshakes, set count and bank muxing.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_cmd, s_value, s_last, s_index
//   m_       out        m_valid/m_ready    m_sorted_value, m_in_range, m_count
//
// A load is written to the bank when accepted. A read is registered in rd_pend_reg and
// the bank read port; m_valid rises once the output register is free. The sort after
// the last load runs on the single compare unit and the one write port of each bank.
// Reset needs no clearing pass; s_ready is low while a sort runs.
// A result waiting on m_ still lets loads and one more read in; that read then holds
// s_ready low until the result is taken.
`include "bottom_up_merge_sorter_top_defines.svh"
module bottom_up_merge_sorter_top
    import bums_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_value,
    input  logic               s_last,
    input  logic [INDEX_W-1:0] s_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sorted_value,
    output logic               m_in_range,
    output logic [10:0]        m_count
);

    bums_mem_req_t mem_req;
    logic          cur_bank;
    logic          busy;

    cnt_t  count_reg, count_next;
    logic  sorted_reg, sorted_next;
    logic  rd_pend_reg, rd_pend_next;
    logic  rd_in_range_reg;
    cnt_t  rd_count_reg;
    logic  m_valid_reg, m_valid_next;
    word_t m_sorted_value_reg;
    logic  m_in_range_reg;
    cnt_t  m_count_reg;

    logic  accept;
    logic  acc_load;
    logic  acc_read;
    logic  out_free;
    cnt_t  base;
    logic  load_room;
    logic  load_we;
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t wr_addr;
    word_t wr_data;
    word_t b0_data_a, b0_data_b, b1_data_a, b1_data_b;
    word_t src_data_a, src_data_b;

    assign accept    = s_valid && s_ready;
    assign acc_load  = accept && (s_cmd == CMD_LOAD);
    assign acc_read  = accept && (s_cmd == CMD_READ);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !busy && (!rd_pend_reg || out_free);
    assign base      = sorted_reg ? '0 : count_reg;
    assign load_room = base < cnt_t'(DEPTH);
    assign load_we   = acc_load && load_room;

    assign rd_en     = busy ? mem_req.rd_en : acc_read;
    assign rd_addr_a = busy ? mem_req.rd_addr_a : addr_t'(s_index);
    assign wr_addr   = busy ? mem_req.wr_addr : base[ADDR_W-1:0];
    assign wr_data   = busy ? mem_req.wr_data : word_t'(s_value);

    assign src_data_a = cur_bank ? b1_data_a : b0_data_a;
    assign src_data_b = cur_bank ? b1_data_b : b0_data_b;

    bums_bank u_bank0 (
        .aclk      (aclk),
        .wr_en     ((load_we && !cur_bank) || (mem_req.wr_en && cur_bank)),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (mem_req.rd_addr_b),
        .rd_data_a (b0_data_a),
        .rd_data_b (b0_data_b)
    );

    bums_bank u_bank1 (
        .aclk      (aclk),
        .wr_en     ((load_we && cur_bank) || (mem_req.wr_en && !cur_bank)),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (mem_req.rd_addr_b),
        .rd_data_a (b1_data_a),
        .rd_data_b (b1_data_b)
    );

    bums_merge_seq u_merge_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (acc_load && s_last),
        .count      (count_next),
        .src_data_a (src_data_a),
        .src_data_b (src_data_b),
        .mem_req    (mem_req),
        .cur_bank   (cur_bank),
        .busy       (busy)
    );

    always_comb begin
        count_next   = count_reg;
        sorted_next  = sorted_reg;
        rd_pend_next = rd_pend_reg;
        m_valid_next = m_valid_reg;
        if (acc_load) begin
            count_next  = load_room ? (base + cnt_t'(1)) : base;
            sorted_next = s_last;
        end
        if (acc_read) begin
            rd_pend_next = 1'b1;
        end else if (out_free) begin
            rd_pend_next = 1'b0;
        end
        if (rd_pend_reg && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sorted_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sorted_reg  <= sorted_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_read) begin
            rd_in_range_reg <= cnt_t'(s_index) < count_reg;
            rd_count_reg    <= count_reg;
        end
        if (rd_pend_reg && out_free) begin
            m_sorted_value_reg <= rd_in_range_reg ? src_data_a : '0;
            m_in_range_reg     <= rd_in_range_reg;
            m_count_reg        <= rd_count_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_sorted_value_reg;
    assign m_in_range     = m_in_range_reg;
    assign m_count        = m_count_reg;

    `BUMS_ASSERT_IMP(a_busy_blocks_input, aclk, aresetn, busy, !s_ready)
    `BUMS_ASSERT_IMP(a_out_of_range_zero, aclk, aresetn, m_valid && !m_in_range, m_sorted_value == 0)
    `BUMS_ASSERT_IMP(a_in_range_nonempty, aclk, aresetn, m_valid && m_in_range, m_count != 0)
    `BUMS_ASSERT_NXT(a_last_starts_sort, aclk, aresetn, acc_load && s_last, busy || (count_reg < cnt_t'(2)))

endmodule

/* rtl/bums_bank.sv */
// One buffer bank: single write port and two registered read ports.
module bums_bank
    import bums_pkg::*;
(
    input  logic  aclk,
    input  logic  wr_en,
    input  addr_t wr_addr,
    input  word_t wr_data,
    input  logic  rd_en,
    input  addr_t rd_addr_a,
    input  addr_t rd_addr_b,
    output word_t rd_data_a,
    output word_t rd_data_b
);

    word_t mem [DEPTH];
    word_t rd_data_a_reg;
    word_t rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* rtl/bums_merge_seq.sv */
// Merge sequencer: one signed compare unit steps through every pass and run.
module bums_merge_seq
    import bums_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  cnt_t          count,
    input  word_t         src_data_a,
    input  word_t         src_data_b,
    output bums_mem_req_t mem_req,
    output logic          cur_bank,
    output logic          busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_CMP   = 2'd3;

    logic [1:0] state_reg, state_next;
    pos_t       n_reg, n_next;
    pos_t       width_reg, width_next;
    pos_t       run_reg, run_next;
    pos_t       mid_reg, mid_next;
    pos_t       hi_reg, hi_next;
    pos_t       a_reg, a_next;
    pos_t       b_reg, b_next;
    pos_t       k_reg, k_next;
    logic       bank_reg, bank_next;

    pos_t sum_mid;
    pos_t sum_hi;
    pos_t k_inc;
    pos_t run_inc;
    pos_t width_dbl;
    logic a_ok;
    logic b_ok;
    logic take_a;

    assign a_ok      = a_reg < mid_reg;
    assign b_ok      = b_reg < hi_reg;
    assign take_a    = a_ok && (!b_ok || ($signed(src_data_a) < $signed(src_data_b)));
    assign sum_mid   = run_reg + width_reg;
    assign width_dbl = width_reg << 1;
    assign sum_hi    = run_reg + width_dbl;
    assign k_inc     = k_reg + pos_t'(1);
    assign run_inc   = run_reg + width_dbl;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        width_next = width_reg;
        run_next   = run_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        bank_next  = bank_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start && (count > cnt_t'(1))) begin
                    n_next     = pos_t'(count);
                    width_next = pos_t'(1);
                    run_next   = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                mid_next   = (sum_mid > n_reg) ? n_reg : sum_mid;
                hi_next    = (sum_hi > n_reg) ? n_reg : sum_hi;
                a_next     = run_reg;
                b_next     = (sum_mid > n_reg) ? n_reg : sum_mid;
                k_next     = run_reg;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (take_a) begin
                    a_next = a_reg + pos_t'(1);
                end else begin
                    b_next = b_reg + pos_t'(1);
                end
                k_next = k_inc;
                if (k_inc == hi_reg) begin
                    if (run_inc >= n_reg) begin
                        bank_next  = !bank_reg;
                        width_next = width_dbl;
                        run_next   = '0;
                        state_next = (width_dbl >= n_reg) ? ST_IDLE : ST_SETUP;
                    end else begin
                        run_next   = run_inc;
                        state_next = ST_SETUP;
                    end
                end else begin
                    state_next = ST_FETCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        width_reg <= width_next;
        run_reg   <= run_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
    end

    assign mem_req.rd_en     = (state_reg == ST_FETCH);
    assign mem_req.wr_en     = (state_reg == ST_CMP);
    assign mem_req.wr_addr   = k_reg[ADDR_W-1:0];
    assign mem_req.wr_data   = take_a ? src_data_a : src_data_b;
    assign mem_req.rd_addr_a = a_reg[ADDR_W-1:0];
    assign mem_req.rd_addr_b = b_reg[ADDR_W-1:0];
    assign cur_bank          = bank_reg;
    assign busy              = (state_reg != ST_IDLE);

endmodule

/* sim/bottom_up_merge_sorter_top_tb.sv */
// Self-checking testbench for the bottom-up merge sorter: loads sets, sorts them and reads them back.
module bottom_up_merge_sorter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bums_pkg::*;

    localparam int STALL_LIMIT = 100000;

    typedef struct {
        logic signed [31:0] sorted_value;
        logic               in_range;
        logic [10:0]        count;
    } read_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_cmd = CMD_LOAD;
    logic signed [31:0] s_value = '0;
    logic               s_last = 1'b0;
    logic [9:0]         s_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_sorted_value;
    logic               m_in_range;
    logic [10:0]        m_count;

    logic signed [31:0] set_words [DEPTH];
    logic signed [31:0] merge_words [DEPTH];
    int                 set_count = 0;
    bit                 set_is_sorted = 1'b0;
    read_result_t       pending_reads [$];

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int loads_sent = 0;
    int reads_sent = 0;
    int sets_sorted = 0;
    int results_checked = 0;

    bottom_up_merge_sorter_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_value        (s_value),
        .s_last         (s_last),
        .s_index        (s_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_in_range     (m_in_range),
        .m_count        (m_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    function automatic void sort_set_words();
        int span, base, mid, stop, a, b, k;
        for (span = 1; span < set_count; span = span * 2) begin
            for (base = 0; base + span < set_count; base = base + 2 * span) begin
                mid = base + span;
                stop = (base + 2 * span > set_count) ? set_count : base + 2 * span;
                a = base;
                b = mid;
                for (k = base; k < stop; k++) begin
                    if (b >= stop || (a < mid && set_words[a] < set_words[b])) begin
                        merge_words[k] = set_words[a];
                        a++;
                    end else begin
                        merge_words[k] = set_words[b];
                        b++;
                    end
                end
                for (k = base; k < stop; k++) begin
                    set_words[k] = merge_words[k];
                end
            end
        end
    endfunction

    function automatic void apply_item(input logic cmd, input logic signed [31:0] value,
                                       input logic last, input logic [9:0] index);
        read_result_t want;
        if (cmd == CMD_LOAD) begin
            if (set_is_sorted) begin
                set_count = 0;
                set_is_sorted = 1'b0;
            end
            if (set_count < DEPTH) begin
                set_words[set_count] = value;
                set_count++;
            end
            if (last) begin
                sort_set_words();
                set_is_sorted = 1'b1;
                sets_sorted++;
            end
            loads_sent++;
        end else begin
            want.in_range = (int'(index) < set_count);
            want.sorted_value = want.in_range ? set_words[index] : '0;
            want.count = 11'(set_count);
            pending_reads.insert(pending_reads.size(), want);
            reads_sent++;
        end
    endfunction

    task automatic send_item(input logic cmd, input logic signed [31:0] value,
                             input logic last, input logic [9:0] index);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= value;
        s_last <= last;
        s_index <= index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(cmd, value, last, index);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll == 0) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        if (roll < 3) return 32'(int'($urandom_range(8)) - 4);
        return 32'($urandom);
    endfunction

    task automatic send_read_near_count();
        int pick;
        logic [9:0] idx;
        pick = $urandom_range(9);
        if (pick < 7 && set_count > 0) idx = 10'($urandom_range(set_count - 1, 0));
        else if (pick == 7) idx = 10'(set_count);
        else idx = 10'($urandom);
        send_item(CMD_READ, 32'($urandom), 1'($urandom), idx);
    endtask

    task automatic test_empty_set();
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd0);
        send_item(CMD_READ, -32'sd1, 1'b1, 10'h3ff);
    endtask

    task automatic test_extreme_values();
        int i;
        send_item(CMD_LOAD, 32'sh7fff_ffff, 1'b0, 10'h3ff);
        send_item(CMD_LOAD, 32'sh8000_0000, 1'b0, 10'd0);
        send_item(CMD_LOAD, 32'sh0, 1'b0, 10'd0);
        send_item(CMD_LOAD, -32'sd1, 1'b0, 10'd0);
        send_item(CMD_LOAD, 32'sd1, 1'b0, 10'd0);
        send_item(CMD_LOAD, 32'sh8000_0000, 1'b0, 10'd0);
        send_item(CMD_LOAD, 32'sh7fff_ffff, 1'b1, 10'd0);
        for (i = 0; i <= 7; i++) send_item(CMD_READ, 32'sh0, 1'b0, 10'(i));
        send_item(CMD_READ, 32'sh0, 1'b0, 10'h3ff);
    endtask

    task automatic test_unsorted_reads();
        send_item(CMD_LOAD, 32'sd50, 1'b0, 10'd0);
        send_item(CMD_LOAD, -32'sd7, 1'b0, 10'd0);
        send_item(CMD_LOAD, 32'sd3, 1'b0, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd2);
        send_item(CMD_LOAD, 32'sd3, 1'b1, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd3);
    endtask

    task automatic test_single_element();
        send_item(CMD_LOAD, 32'sh5a5a_a5a5, 1'b1, 10'h2aa);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd1);
    endtask

    task automatic test_random_sets(input int budget);
        int sent_items, set_size, n_reads, i;
        logic end_of_set;
        sent_items = 0;
        while (sent_items < budget) begin
            set_size = ($urandom_range(9) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 1);
            end_of_set = ($urandom_range(6) != 0);
            for (i = 0; i < set_size; i++) begin
                if ($urandom_range(19) == 0) begin
                    send_read_near_count();
                    sent_items++;
                end
                send_item(CMD_LOAD, pick_value(), end_of_set && (i == set_size - 1),
                          10'($urandom));
                sent_items++;
            end
            n_reads = $urandom_range(set_size + 2, 1);
            for (i = 0; i < n_reads; i++) begin
                send_read_near_count();
                sent_items++;
            end
        end
    endtask

    task automatic test_full_buffer();
        int i;
        for (i = 0; i < DEPTH; i++) send_item(CMD_LOAD, pick_value(), 1'b0, 10'($urandom));
        send_item(CMD_READ, 32'sh0, 1'b0, 10'(DEPTH - 1));
        send_item(CMD_READ, 32'sh0, 1'b0, 10'($urandom));
        send_item(CMD_LOAD, pick_value(), 1'b0, 10'd0);
        send_item(CMD_LOAD, pick_value(), 1'b1, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'd0);
        send_item(CMD_READ, 32'sh0, 1'b0, 10'(DEPTH - 1));
        for (i = 0; i < 16; i++) send_read_near_count();
    endtask

    always @(posedge aclk) begin
        read_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                $error("result with no read waiting: sorted_value %0d, count %0d",
                       m_sorted_value, m_count);
                error_count++;
            end else begin
                want = pending_reads.pop_front();
                if (m_sorted_value !== want.sorted_value) begin
                    $error("sorted_value expected %0d, got %0d", want.sorted_value,
                           m_sorted_value);
                    error_count++;
                end
                if (m_in_range !== want.in_range) begin
                    $error("in_range expected %0d, got %0d", want.in_range, m_in_range);
                    error_count++;
                end
                if (m_count !== want.count) begin
                    $error("count expected %0d, got %0d", want.count, m_count);
                    error_count++;
                end
                results_checked++;
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("No item moved for %0d cycles.", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sender_idle_pct = 6;
        receiver_idle_pct = 69;
        test_empty_set();
        test_extreme_values();
        test_unsorted_reads();
        test_single_element();
        test_random_sets(300);

        sender_idle_pct = 69;
        receiver_idle_pct = 6;
        test_random_sets(300);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_full_buffer();
        test_random_sets(270);

        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d loads and %0d reads; %0d sets were sorted, one of them full.",
                 loads_sent, reads_sent, sets_sorted);
        $display("Checked %0d read results with %0d mismatches.", results_checked, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
